>>> hw/rtl/sitda_pkg.sv
// Shared constants, types and payload struct for the signed integer to decimal text converter.
package sitda_pkg;

   localparam int ValueWidth    = 64;
   localparam int NumDigits     = 19;
   localparam int DigitWidth    = 4;
   localparam int BcdWidth      = NumDigits * DigitWidth;
   localparam int BitsPerStage  = 8;
   localparam int NumBcdStages  = ValueWidth / BitsPerStage;
   localparam int DigitIdxWidth = $clog2(NumDigits);
   localparam int CharWidth     = 8;

   localparam logic [CharWidth-1:0]  CharZero  = 8'h30;
   localparam logic [CharWidth-1:0]  CharMinus = 8'h2D;
   localparam logic [DigitWidth-1:0] DigitFive = 4'd5;
   localparam logic [DigitWidth-1:0] DigitBias = 4'd3;

   // Data carried down the conversion pipeline.
   typedef struct packed {
      logic                  neg;
      logic [BcdWidth-1:0]   bcd;
      logic [ValueWidth-1:0] mag;
   } pipe_type;

endpackage

>>> hw/rtl/sitda_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface sitda_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sitda_pkg::ValueWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitda_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sitda_pkg::CharWidth-1:0]     text_char;
   logic                                last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

>>> hw/rtl/sitda_bcd_stage.sv
// One register stage of the binary to BCD conversion, eight shift-and-adjust steps deep.
module sitda_bcd_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  sitda_pkg::pipe_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output sitda_pkg::pipe_type out_data
);

   logic                valid_ff;
   logic                valid_in;
   sitda_pkg::pipe_type data_ff;
   sitda_pkg::pipe_type data_in;
   logic                load;

   // Each step adjusts every digit of five or more by three, then shifts in the next bit.
   always_comb begin
      logic [sitda_pkg::BcdWidth-1:0]   bcd;
      logic [sitda_pkg::ValueWidth-1:0] mag;
      bcd = in_data.bcd;
      mag = in_data.mag;
      for (int s = 0; s < sitda_pkg::BitsPerStage; s++) begin
         for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
            if (bcd[d*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] >= sitda_pkg::DigitFive) begin
               bcd[d*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] =
                  bcd[d*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] + sitda_pkg::DigitBias;
            end
         end
         bcd = {bcd[sitda_pkg::BcdWidth-2:0], mag[sitda_pkg::ValueWidth-1]};
         mag = {mag[sitda_pkg::ValueWidth-2:0], 1'b0};
      end
      data_in.neg = in_data.neg;
      data_in.bcd = bcd;
      data_in.mag = mag;
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/sitda_serializer.sv
// Holds one converted value and sends its characters out one per cycle while rsp.ready is high, leading zeros dropped.
module sitda_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sitda_pkg::pipe_type in_data,
   sitda_rsp_if.source         rsp
);

   logic                                busy_ff;
   logic                                busy_in;
   logic                                neg_ff;
   logic                                neg_in;
   logic [sitda_pkg::DigitIdxWidth-1:0] pos_ff;
   logic [sitda_pkg::DigitIdxWidth-1:0] pos_in;
   logic [sitda_pkg::DigitWidth-1:0]    digits_ff [sitda_pkg::NumDigits];
   logic [sitda_pkg::DigitIdxWidth-1:0] top_digit;
   logic                                cur_last;
   logic                                out_fire;
   logic                                load;

   // Index of the most significant nonzero digit; zero when the value is zero.
   always_comb begin
      top_digit = '0;
      for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
         if (in_data.bcd[d*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] != '0) begin
            top_digit = sitda_pkg::DigitIdxWidth'(d);
         end
      end
   end

   assign cur_last = !neg_ff && (pos_ff == '0);
   assign out_fire = busy_ff && rsp.ready;
   assign in_ready = !busy_ff || (rsp.ready && cur_last);
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         neg_in  = in_data.neg;
         pos_in  = top_digit;
      end else if (out_fire) begin
         if (neg_ff) begin
            neg_in = 1'b0;
         end else if (pos_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      pos_ff <= pos_in;
      if (load) begin
         for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
            digits_ff[d] <= in_data.bcd[d*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth];
         end
      end
   end

   assign rsp.valid     = busy_ff;
   assign rsp.last_char = cur_last;
   assign rsp.text_char = neg_ff ? sitda_pkg::CharMinus
                                 : sitda_pkg::CharZero + {4'b0000, digits_ff[pos_ff]};

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii_top.sv
// Top level of the signed 64-bit integer to decimal ASCII text converter.
//
// Usage: a request on req_chan carries one signed 64-bit value. The block answers
// with its decimal text on rsp_chan, one ASCII character per response, most
// significant first: a minus sign for negative values, then the digits with
// leading zeros dropped. Zero gives a single '0'. last_char marks the final
// character of each value, so a run is 1 to 20 responses long.
// Path: the first character of a value goes through the magnitude register, each
// of the eight BCD conversion stages and the serializer's own register, which
// drives it as soon as it loads, when nothing is ahead of it.
// Throughput: the serializer sends one character per cycle while the receiver is ready,
// so a value holds it until all of its characters (1 to 20) are sent; the pipeline in front
// of it holds up to nine more requests, and req_chan.ready drops only when all
// of those stages are full. A stalled receiver freezes the current character
// and backs up the pipeline without losing or repeating anything.
// Reset is synchronous and active high; it empties every stage and the
// serializer, after which the block accepts a request at once.
module signed_int_to_decimal_ascii_top (
   input  logic       clock,
   input  logic       reset,
   sitda_req_if.sink  req_chan,
   sitda_rsp_if.source rsp_chan
);

   logic                in_valid_ff;
   logic                in_valid_in;
   sitda_pkg::pipe_type in_data_ff;
   sitda_pkg::pipe_type in_data_in;
   logic                in_load;

   logic                pipe_valid [sitda_pkg::NumBcdStages+1];
   logic                pipe_ready [sitda_pkg::NumBcdStages+1];
   sitda_pkg::pipe_type pipe_data  [sitda_pkg::NumBcdStages+1];

   // Input stage: take the magnitude as an unsigned quantity, which also covers
   // the most negative value exactly.
   assign req_chan.ready = !in_valid_ff || pipe_ready[0];
   assign in_load        = req_chan.valid && req_chan.ready;
   assign in_valid_in    = in_load ? 1'b1 : (pipe_ready[0] ? 1'b0 : in_valid_ff);

   always_comb begin
      in_data_in.neg = req_chan.value[sitda_pkg::ValueWidth-1];
      in_data_in.bcd = '0;
      in_data_in.mag = in_data_in.neg ? (sitda_pkg::ValueWidth'(0) - req_chan.value)
                                      : req_chan.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= in_data_in;
      end
   end

   assign pipe_valid[0] = in_valid_ff;
   assign pipe_data[0]  = in_data_ff;

   // Binary to BCD conversion, eight input bits per stage, most significant first.
   for (genvar g = 0; g < sitda_pkg::NumBcdStages; g++) begin : g_bcd
      sitda_bcd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[g]),
         .in_ready  (pipe_ready[g]),
         .in_data   (pipe_data[g]),
         .out_valid (pipe_valid[g+1]),
         .out_ready (pipe_ready[g+1]),
         .out_data  (pipe_data[g+1])
      );
   end

   // The serializer turns the finished digits into the character stream.
   sitda_serializer u_ser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pipe_valid[sitda_pkg::NumBcdStages]),
      .in_ready (pipe_ready[sitda_pkg::NumBcdStages]),
      .in_data  (pipe_data[sitda_pkg::NumBcdStages]),
      .rsp      (rsp_chan)
   );

   // A minus sign always has digits after it.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.text_char == sitda_pkg::CharMinus) |-> !rsp_chan.last_char)
      else $error("minus sign flagged as last character");

   // Every character is a minus sign or a decimal digit.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.text_char == sitda_pkg::CharMinus ||
                          (rsp_chan.text_char >= sitda_pkg::CharZero &&
                           rsp_chan.text_char <= 8'h39)))
      else $error("character outside minus and digits");

   // A character taken after a minus sign starts the digits and is never a zero.
   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.text_char == sitda_pkg::CharMinus)
      |=> (rsp_chan.text_char != sitda_pkg::CharZero))
      else $error("leading zero after minus sign");

   // The input stage never drops a held value while the conversion pipeline is full.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !pipe_ready[0]) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input stage lost a held value");

endmodule
